/* hw/rtl/sawbc_pkg.sv */
// ----------------------------------------------------------------------------
// sawbc_pkg
// Shared constants and types for the set-associative write-back cache
// tag controller.
// ----------------------------------------------------------------------------
package sawbc_pkg;

   localparam int SETS_DEF      = 256;
   localparam int WAYS_DEF      = 8;
   localparam int ADDR_BITS_DEF = 32;

   localparam int OFS_W  = 3;
   localparam int IDX_W  = 4;
   localparam int WIU_W  = 4;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 4;
   localparam int SHIFT_W = 5;

   localparam logic [CSR_IW-1:0] CSR_OFFSET_WIDTH = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_INDEX_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_WAYS_IN_USE  = 2'd2;

   localparam logic [OFS_W-1:0] OFS_RESET = 3'd5;
   localparam logic [IDX_W-1:0] IDX_RESET = 4'd8;
   localparam logic [WIU_W-1:0] WIU_RESET = 4'd8;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK,
      BK_UPDATE
   } back_state_type;

endpackage

/* hw/rtl/set_assoc_lru_writeback_cache_top.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_top
// Tag and state controller of a set-associative, write-back, write-allocate
// cache with true LRU replacement.
//
//   Channel   Ports                          Beat taken when
//   request   start, busy, req_*             start && !busy
//   response  rsp_valid, rsp_*               rsp_valid (one cycle)
//   config    csr_valid, csr_ready, csr_*    csr_valid && csr_ready
//
// Each access passes through the back end as row read, tag compare and row
// write, and the back end takes no new access until that row write is done.
// A two-entry queue lets two more accesses be taken while one is worked on.
// After reset a clearing pass runs over every set with busy high.
// The response is registered in the cycle after the row write and cannot be stalled.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_top import sawbc_pkg::*; #(
   parameter int SETS      = SETS_DEF,
   parameter int WAYS      = WAYS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [31:0]       req_address,
   input  logic              req_is_store,
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [2:0]        rsp_way_used,
   output logic              rsp_writeback_valid,
   output logic [31:0]       rsp_writeback_address,
   output logic              rsp_fill_valid,
   output logic [31:0]       rsp_fill_address,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int NW_W    = $clog2(WAYS + 1);
   localparam int IDX_MAX = $clog2(SETS + 1) - 1;

   logic [OFS_W-1:0] ofs_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [WIU_W-1:0] wiu_ff;
   logic [IDX_W-1:0] idx_eff;
   logic [NW_W-1:0]  n_ways;

   logic                 q_full, q_not_empty, q_pop, q_store, clearing;
   logic [SET_W-1:0]     q_set;
   logic [ADDR_BITS-1:0] q_tag, q_blk;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff <= OFS_RESET;
         idx_ff <= IDX_RESET;
         wiu_ff <= WIU_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_WIDTH: ofs_ff <= csr_wdata[OFS_W-1:0];
            CSR_INDEX_WIDTH:  idx_ff <= csr_wdata[IDX_W-1:0];
            CSR_WAYS_IN_USE:  wiu_ff <= csr_wdata[WIU_W-1:0];
            default:          ofs_ff <= ofs_ff;
         endcase
      end
   end

   always_comb begin
      idx_eff = (idx_ff > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : idx_ff;
      if (wiu_ff == '0) begin
         n_ways = NW_W'(1);
      end else if ({1'b0, wiu_ff} > 5'(WAYS)) begin
         n_ways = NW_W'(WAYS);
      end else begin
         n_ways = NW_W'(wiu_ff);
      end
   end

   assign busy = q_full || clearing;

   sawbc_front #(
      .SETS      (SETS),
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (start && !busy),
      .address    (req_address),
      .is_store   (req_is_store),
      .ofs_w      (ofs_ff),
      .idx_w      (idx_eff),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head_set   (q_set),
      .head_tag   (q_tag),
      .head_blk   (q_blk),
      .head_store (q_store)
   );

   sawbc_back #(
      .SETS      (SETS),
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_not_empty           (q_not_empty),
      .q_set                 (q_set),
      .q_tag                 (q_tag),
      .q_blk                 (q_blk),
      .q_store               (q_store),
      .ofs_w                 (ofs_ff),
      .idx_w                 (idx_eff),
      .n_ways                (n_ways),
      .q_pop                 (q_pop),
      .clearing              (clearing),
      .rsp_valid             (rsp_valid),
      .rsp_hit               (rsp_hit),
      .rsp_way_used          (rsp_way_used),
      .rsp_writeback_valid   (rsp_writeback_valid),
      .rsp_writeback_address (rsp_writeback_address),
      .rsp_fill_valid        (rsp_fill_valid),
      .rsp_fill_address      (rsp_fill_address)
   );

endmodule

/* hw/rtl/sawbc_front.sv */
// ----------------------------------------------------------------------------
// sawbc_front
// Accepts access beats, splits the address into set, tag and block address,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sawbc_front import sawbc_pkg::*; #(
   parameter int SETS      = SETS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int SET_W     = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [31:0]          address,
   input  logic                 is_store,
   input  logic [OFS_W-1:0]     ofs_w,
   input  logic [IDX_W-1:0]     idx_w,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output logic [SET_W-1:0]     head_set,
   output logic [ADDR_BITS-1:0] head_tag,
   output logic [ADDR_BITS-1:0] head_blk,
   output logic                 head_store
);

   logic [ADDR_BITS-1:0] addr_m;
   logic [ADDR_BITS-1:0] set_full;
   logic [ADDR_BITS-1:0] set_mask;
   logic [SHIFT_W-1:0]   shift;
   logic [SET_W-1:0]     set_c;
   logic [ADDR_BITS-1:0] tag_c;
   logic [ADDR_BITS-1:0] blk_c;

   logic [SET_W-1:0]     q_set_ff   [2];
   logic [ADDR_BITS-1:0] q_tag_ff   [2];
   logic [ADDR_BITS-1:0] q_blk_ff   [2];
   logic                 q_store_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   always_comb begin
      addr_m   = address[ADDR_BITS-1:0];
      set_mask = ~({ADDR_BITS{1'b1}} << idx_w);
      set_full = (addr_m >> ofs_w) & set_mask;
      set_c    = set_full[SET_W-1:0];
      shift    = SHIFT_W'(ofs_w) + SHIFT_W'(idx_w);
      tag_c    = addr_m >> shift;
      blk_c    = (addr_m >> ofs_w) << ofs_w;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_set_ff[wr_ptr_ff]   <= set_c;
         q_tag_ff[wr_ptr_ff]   <= tag_c;
         q_blk_ff[wr_ptr_ff]   <= blk_c;
         q_store_ff[wr_ptr_ff] <= is_store;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign not_empty  = (count_ff != 2'd0);
   assign head_set   = q_set_ff[rd_ptr_ff];
   assign head_tag   = q_tag_ff[rd_ptr_ff];
   assign head_blk   = q_blk_ff[rd_ptr_ff];
   assign head_store = q_store_ff[rd_ptr_ff];

endmodule

/* hw/rtl/sawbc_back.sv */
// ----------------------------------------------------------------------------
// sawbc_back
// Holds the tag, valid, dirty and rank memories, looks up one queued access
// at a time, updates the set and produces the result beat.
// ----------------------------------------------------------------------------
module sawbc_back import sawbc_pkg::*; #(
   parameter int SETS      = SETS_DEF,
   parameter int WAYS      = WAYS_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int SET_W     = (SETS > 1) ? $clog2(SETS) : 1,
   parameter int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1,
   parameter int NW_W      = $clog2(WAYS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  logic [SET_W-1:0]     q_set,
   input  logic [ADDR_BITS-1:0] q_tag,
   input  logic [ADDR_BITS-1:0] q_blk,
   input  logic                 q_store,
   input  logic [OFS_W-1:0]     ofs_w,
   input  logic [IDX_W-1:0]     idx_w,
   input  logic [NW_W-1:0]      n_ways,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic [2:0]           rsp_way_used,
   output logic                 rsp_writeback_valid,
   output logic [31:0]          rsp_writeback_address,
   output logic                 rsp_fill_valid,
   output logic [31:0]          rsp_fill_address
);

   typedef logic [WAYS-1:0][ADDR_BITS-1:0] tag_row_type;
   typedef logic [WAYS-1:0][WAY_W-1:0]     rank_row_type;

   tag_row_type  tag_mem   [SETS];
   logic [WAYS-1:0] valid_mem [SETS];
   logic [WAYS-1:0] dirty_mem [SETS];
   rank_row_type rank_mem  [SETS];

   back_state_type state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff, clr_cnt_in;

   tag_row_type     rd_tag_ff;
   logic [WAYS-1:0] rd_valid_ff;
   logic [WAYS-1:0] rd_dirty_ff;
   rank_row_type    rd_rank_ff;

   logic [SET_W-1:0]     job_set_ff;
   logic [ADDR_BITS-1:0] job_tag_ff;
   logic [ADDR_BITS-1:0] job_blk_ff;
   logic                 job_store_ff;

   logic             hit_c, hit_ff;
   logic [WAY_W-1:0] found_c, victim_c, way_c, way_ff;

   logic             mem_we;
   logic [SET_W-1:0] mem_addr;
   tag_row_type      wr_tag;
   logic [WAYS-1:0]  wr_valid;
   logic [WAYS-1:0]  wr_dirty;
   rank_row_type     wr_rank;

   logic [WAY_W-1:0]     sel_rank;
   logic                 wb_c;
   logic [SHIFT_W-1:0]   shift;
   logic [ADDR_BITS-1:0] wb_addr_c;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [2:0]           rsp_way_ff;
   logic                 rsp_wb_ff;
   logic [31:0]          rsp_wb_addr_ff;
   logic                 rsp_fill_ff;
   logic [31:0]          rsp_fill_addr_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR:  if (clr_cnt_ff == SET_W'(SETS - 1)) state_in = BK_IDLE;
         BK_IDLE:   if (q_not_empty) state_in = BK_LOOK;
         BK_LOOK:   state_in = BK_UPDATE;
         BK_UPDATE: state_in = BK_IDLE;
         default:   state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      clearing = 1'b0;
      mem_we   = 1'b0;
      mem_addr = job_set_ff;
      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         BK_IDLE:   q_pop = q_not_empty;
         BK_UPDATE: mem_we = 1'b1;
         default:   q_pop = 1'b0;
      endcase
   end

   assign clr_cnt_in = (state_ff == BK_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= (state_ff == BK_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_tag_ff    <= tag_mem[q_set];
         rd_valid_ff  <= valid_mem[q_set];
         rd_dirty_ff  <= dirty_mem[q_set];
         rd_rank_ff   <= rank_mem[q_set];
         job_set_ff   <= q_set;
         job_tag_ff   <= q_tag;
         job_blk_ff   <= q_blk;
         job_store_ff <= q_store;
      end
      if (mem_we) begin
         tag_mem[mem_addr]   <= wr_tag;
         valid_mem[mem_addr] <= wr_valid;
         dirty_mem[mem_addr] <= wr_dirty;
         rank_mem[mem_addr]  <= wr_rank;
      end
   end

   always_comb begin
      hit_c    = 1'b0;
      found_c  = '0;
      victim_c = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_c && (NW_W'(w) < n_ways) && rd_valid_ff[w] &&
             (rd_tag_ff[w] == job_tag_ff)) begin
            hit_c   = 1'b1;
            found_c = WAY_W'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if ((NW_W'(w) < n_ways) && (rd_rank_ff[w] > rd_rank_ff[victim_c])) begin
            victim_c = WAY_W'(w);
         end
      end
      way_c = hit_c ? found_c : victim_c;
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_LOOK) begin
         hit_ff <= hit_c;
         way_ff <= way_c;
      end
   end

   always_comb begin
      sel_rank  = rd_rank_ff[way_ff];
      shift     = SHIFT_W'(ofs_w) + SHIFT_W'(idx_w);
      wb_c      = !hit_ff && rd_valid_ff[way_ff] && rd_dirty_ff[way_ff];
      wb_addr_c = (rd_tag_ff[way_ff] << shift) |
                  (ADDR_BITS'(job_set_ff) << ofs_w);
      if (state_ff == BK_CLEAR) begin
         wr_tag   = '0;
         wr_valid = '0;
         wr_dirty = '0;
         for (int w = 0; w < WAYS; w++) begin
            wr_rank[w] = WAY_W'(w);
         end
      end else begin
         wr_tag   = rd_tag_ff;
         wr_valid = rd_valid_ff;
         wr_dirty = rd_dirty_ff;
         wr_rank  = rd_rank_ff;
         for (int w = 0; w < WAYS; w++) begin
            if ((NW_W'(w) < n_ways) && (rd_rank_ff[w] < sel_rank)) begin
               wr_rank[w] = rd_rank_ff[w] + 1'b1;
            end
         end
         wr_rank[way_ff] = '0;
         if (hit_ff) begin
            if (job_store_ff) begin
               wr_dirty[way_ff] = 1'b1;
            end
         end else begin
            wr_tag[way_ff]   = job_tag_ff;
            wr_valid[way_ff] = 1'b1;
            wr_dirty[way_ff] = job_store_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_UPDATE) begin
         rsp_hit_ff       <= hit_ff;
         rsp_way_ff       <= 3'(way_ff);
         rsp_wb_ff        <= wb_c;
         rsp_wb_addr_ff   <= wb_c ? 32'(wb_addr_c) : 32'd0;
         rsp_fill_ff      <= !hit_ff;
         rsp_fill_addr_ff <= hit_ff ? 32'd0 : 32'(job_blk_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_way_used          = rsp_way_ff;
   assign rsp_writeback_valid   = rsp_wb_ff;
   assign rsp_writeback_address = rsp_wb_addr_ff;
   assign rsp_fill_valid        = rsp_fill_ff;
   assign rsp_fill_address      = rsp_fill_addr_ff;

endmodule

/* hw/rtl/sawbc_checker.sv */
// ----------------------------------------------------------------------------
// sawbc_checker
// Port-level checks on the cache controller's response beats and reset.
// ----------------------------------------------------------------------------
module sawbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic        rsp_writeback_valid,
   input logic [31:0] rsp_writeback_address,
   input logic        rsp_fill_valid,
   input logic [31:0] rsp_fill_address
);

   a_hit_xor_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit != rsp_fill_valid))
      else $error("A response beat must be either a hit or a fill.");

   a_hit_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (!rsp_writeback_valid && rsp_fill_address == 32'd0))
      else $error("A hit must not request a write-back or a fill.");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_writeback_valid) |-> (rsp_writeback_address == 32'd0))
      else $error("The write-back address must be zero without a write-back.");

   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Response beats must not come in consecutive cycles.");

   a_clear_busy: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> busy)
      else $error("The block must be busy right after reset.");

endmodule

bind set_assoc_lru_writeback_cache_top sawbc_checker u_sawbc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_hit               (rsp_hit),
   .rsp_writeback_valid   (rsp_writeback_valid),
   .rsp_writeback_address (rsp_writeback_address),
   .rsp_fill_valid        (rsp_fill_valid),
   .rsp_fill_address      (rsp_fill_address)
);
